// ----- rtl/core/kpat_pkg.sv -----
// Package with shared types and codes of the keyed point average table.
`timescale 1ns / 1ps
package kpat_pkg;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpDump  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [2:0] StAdded    = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StSat      = 3'd2;
  localparam logic [2:0] StDumpEnt  = 3'd3;
  localparam logic [2:0] StDumpNone = 3'd4;
  localparam logic [2:0] StCleared  = 3'd5;

  localparam int unsigned SumBits = 48;
  localparam int unsigned IdBits  = 32;
  localparam int unsigned CrdBits = 32;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] point_id;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] group_id;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic [15:0] point_count;
    logic        last;
  } out_item_t;

  // Control from the top level to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

// ----- rtl/core/kpat_if.sv -----
// Valid/ready channel interfaces for the input and result transfers.
`timescale 1ns / 1ps
interface kpat_in_if import kpat_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kpat_out_if import kpat_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/kpat_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module kpat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/kpat_div.sv -----
// Restoring divider: signed 48-bit sum by unsigned count, one bit a cycle.
`timescale 1ns / 1ps
module kpat_div import kpat_pkg::*; #(
  parameter int unsigned CountBits = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  div_ctl_t                  ctl_i,
  input  logic signed [SumBits-1:0] sum_i,
  input  logic [CountBits-1:0]      count_i,
  output logic                      done_o,
  output logic signed [31:0]        mean_o
);
  localparam int unsigned StepBits = $clog2(SumBits + 1);

  logic [SumBits-1:0]   quo_q, quo_d;
  logic [CountBits:0]   rem_q, rem_d;
  logic [CountBits-1:0] den_q;
  logic                 neg_q;
  logic [StepBits-1:0]  step_q;
  logic                 busy_q;
  logic [CountBits:0]   trial;
  logic [SumBits-1:0]   mag;
  logic [SumBits:0]     sq;

  assign mag = sum_i[SumBits-1] ? SumBits'(-sum_i) : sum_i;

  always_comb begin
    trial = {rem_q[CountBits-1:0], quo_q[SumBits-1]};
    quo_d = {quo_q[SumBits-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepBits'(SumBits);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= count_i;
      neg_q <= sum_i[SumBits-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Apply the sign, then clamp to the 32-bit range.
  always_comb begin
    sq = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
    if (!neg_q && quo_q > SumBits'(32'h7fff_ffff)) begin
      mean_o = 32'sh7fff_ffff;
    end else if (neg_q && quo_q > SumBits'(33'h0_8000_0000)) begin
      mean_o = 32'sh8000_0000;
    end else begin
      mean_o = sq[31:0];
    end
  end
endmodule

// ----- rtl/core/keyed_point_average_table.sv -----
// Top level of the keyed point average table.
`timescale 1ns / 1ps
//
//  Channel  Dir  Modport  Carries
//  in_i     in   sink     op, point_id, x/y/z coordinates
//  out_o    out  source   status, group_id, means, point_count, last
//
// An add searches the table one slot at a time through the ID memory. Each
// slot costs an address state and a compare state, because the memory has a
// registered read. A dump handles each entry in turn: a read state, a start
// state, three runs of the bit-serial divider, one per coordinate, and the
// output state. A clear resets the fill count and goes straight to output.
// Reset empties the table at once through the fill count; the memories need
// no clearing pass. A result waits in the output register while out_o stalls;
// no new item is taken meanwhile.
module keyed_point_average_table import kpat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpat_in_if.sink   in_i,
  kpat_out_if.source out_o
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned DW = IdBits + 3 * SumBits + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_UPD    = 4'd4;
  localparam logic [3:0] S_OUT    = 4'd5;
  localparam logic [3:0] S_DRD    = 4'd6;
  localparam logic [3:0] S_DX     = 4'd7;
  localparam logic [3:0] S_DY     = 4'd8;
  localparam logic [3:0] S_DZ     = 4'd9;
  localparam logic [3:0] S_DST    = 4'd10;

  logic [3:0]   state_q;
  logic [UW-1:0] used_q;
  logic [UW-1:0] idx_q;
  in_item_t     item_q;
  out_item_t    res_q;
  logic         busy;

  // The ID memory is searched; the data memory holds the sums and count.
  logic              id_we;
  logic [AW-1:0]     id_raddr;
  logic [IdBits-1:0] id_rdata;
  logic              d_we;
  logic [AW-1:0]     d_raddr;
  logic [DW-1:0]     d_wdata, d_rdata;
  logic              new_q;

  logic signed [SumBits-1:0] sx, sy, sz;
  logic [COUNT_BITS-1:0]     cnt;
  logic signed [SumBits-1:0] nx, ny, nz;
  logic [COUNT_BITS-1:0]     ncnt;

  div_ctl_t          dctl;
  logic signed [SumBits-1:0] dsum;
  logic              ddone;
  logic signed [31:0] dmean;
  logic signed [31:0] mx_q, my_q;

  assign busy       = (state_q != S_IDLE);
  assign in_i.ready = !busy;
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = res_q;

  assign id_raddr = idx_q[AW-1:0];
  assign d_raddr  = idx_q[AW-1:0];
  assign {sx, sy, sz, cnt} = new_q ? '0 : d_rdata[DW-IdBits-1:0];
  assign nx   = sx + SumBits'(item_q.x_coord);
  assign ny   = sy + SumBits'(item_q.y_coord);
  assign nz   = sz + SumBits'(item_q.z_coord);
  assign ncnt = cnt + 1'b1;
  assign id_we   = (state_q == S_UPD) && new_q;
  assign d_we    = (state_q == S_UPD) && (cnt != CountMax);
  assign d_wdata = {item_q.point_id, nx, ny, nz, ncnt};

  kpat_ram #(.Width(IdBits), .Depth(1 << AW)) u_id_ram (
    .clk_i, .we_i(id_we), .waddr_i(idx_q[AW-1:0]), .wdata_i(item_q.point_id),
    .raddr_i(id_raddr), .rdata_o(id_rdata)
  );

  kpat_ram #(.Width(DW), .Depth(1 << AW)) u_data_ram (
    .clk_i, .we_i(d_we), .waddr_i(idx_q[AW-1:0]), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  // Stored sums feed the divider one coordinate at a time. Each division is
  // started in the cycle that finishes the one before, so the sum selected
  // in a state is the one for the next coordinate.
  always_comb begin
    unique case (state_q)
      S_DX:    dsum = sy;
      S_DY:    dsum = sz;
      default: dsum = sx;
    endcase
  end
  assign dctl.start = (state_q == S_DST) ||
                      (ddone && (state_q == S_DX || state_q == S_DY));

  kpat_div #(.CountBits(COUNT_BITS)) u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .sum_i(dsum), .count_i(cnt),
    .done_o(ddone), .mean_o(dmean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      new_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          new_q <= 1'b0;
          if (in_i.valid) begin
            unique case (in_i.data.op)
              OpAdd:   state_q <= (used_q == '0) ? S_RD : S_SRCH;
              OpDump:  state_q <= (used_q == '0) ? S_OUT : S_DRD;
              OpClear: begin
                used_q  <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_IDLE;
            endcase
            if (in_i.data.op == OpAdd && used_q == '0) begin
              new_q <= 1'b1;
            end
          end
        end
        // Address is presented; data arrives in S_CMP.
        S_SRCH: state_q <= S_CMP;
        S_CMP: begin
          if (id_rdata == item_q.point_id) begin
            state_q <= S_RD;
          end else if (idx_q + 1'b1 == used_q) begin
            if (used_q == UW'(TABLE_ENTRIES)) begin
              state_q <= S_OUT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              new_q   <= 1'b1;
              state_q <= S_RD;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SRCH;
          end
        end
        S_RD: state_q <= S_UPD;
        S_UPD: begin
          if (new_q) begin
            used_q <= used_q + 1'b1;
          end
          state_q <= S_OUT;
        end
        // The entry's address is presented; its data is ready in S_DST.
        S_DRD: state_q <= S_DST;
        S_DST: state_q <= S_DX;
        S_DX:  if (ddone) state_q <= S_DY;
        S_DY:  if (ddone) state_q <= S_DZ;
        S_DZ:  if (ddone) state_q <= S_OUT;
        S_OUT: begin
          if (out_o.ready) begin
            if (item_q.op == OpDump && !res_q.last) begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_DRD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      item_q <= in_i.data;
      res_q  <= '{status: (in_i.data.op == OpDump) ? StDumpNone : StCleared,
                  last: 1'b1, default: '0};
    end
    if (state_q == S_CMP && id_rdata != item_q.point_id &&
        idx_q + 1'b1 == used_q && used_q == UW'(TABLE_ENTRIES)) begin
      res_q.status   <= StFull;
      res_q.group_id <= item_q.point_id;
    end
    if (state_q == S_UPD) begin
      res_q.group_id <= item_q.point_id;
      if (cnt == CountMax) begin
        res_q.status      <= StSat;
        res_q.point_count <= 16'(cnt);
      end else begin
        res_q.status      <= StAdded;
        res_q.point_count <= 16'(ncnt);
      end
    end
    if (ddone && state_q == S_DX) mx_q <= dmean;
    if (ddone && state_q == S_DY) my_q <= dmean;
    if (ddone && state_q == S_DZ) begin
      res_q.status      <= StDumpEnt;
      res_q.group_id    <= d_rdata[DW-1 -: IdBits];
      res_q.mean_x      <= mx_q;
      res_q.mean_y      <= my_q;
      res_q.mean_z      <= dmean;
      res_q.point_count <= 16'(cnt);
      res_q.last        <= (idx_q + 1'b1 == used_q);
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_ENTRIES)) else $error("fill count beyond table");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res_q))
    else $error("result changed while stalled");
`endif
endmodule

// ----- tb/sv/keyed_point_average_table_tb.sv -----
// Self-checking testbench of the keyed point average table, with a predictor and idle patterns.
`timescale 1ns / 1ps
module keyed_point_average_table_tb;
  import kpat_pkg::*;

  localparam int unsigned Slots     = 16;
  localparam int unsigned CountMax  = 65535;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;

  kpat_in_if  in_ch ();
  kpat_out_if out_ch ();

  keyed_point_average_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Predictor's own copy of the table. Slots below fill_count are live and
  // sit in order of first appearance, exactly as the block reports them.
  logic [31:0]        grp_ids  [Slots];
  logic signed [47:0] grp_sx   [Slots];
  logic signed [47:0] grp_sy   [Slots];
  logic signed [47:0] grp_sz   [Slots];
  logic [15:0]        grp_cnt  [Slots];
  int unsigned        fill_count;

  out_item_t pending_results[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  bit          stim_done;

  // Truncating mean, clamped to the signed 32-bit range.
  function automatic logic signed [31:0] group_mean(logic signed [47:0] total,
                                                    logic [15:0] cnt);
    longint q;
    if (cnt == 0) return '0;
    q = longint'(total) / longint'({48'd0, cnt});
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic out_item_t make_result(logic [2:0] st, logic [31:0] gid,
                                            logic [15:0] cnt, logic lst);
    out_item_t r;
    r = '0;
    r.status = st;
    r.group_id = gid;
    r.point_count = cnt;
    r.last = lst;
    return r;
  endfunction

  // Applies one accepted item to the table copy and queues what it yields.
  task automatic predict_table(input in_item_t it);
    int slot;
    out_item_t r;
    slot = -1;
    case (it.op)
      OpAdd: begin
        for (int i = 0; i < int'(fill_count); i++) begin
          if (slot < 0 && grp_ids[i] == it.point_id) slot = i;
        end
        if (slot < 0 && fill_count >= Slots) begin
          pending_results.push_back(make_result(StFull, it.point_id, '0, 1'b1));
        end else begin
          if (slot < 0) begin
            slot = fill_count;
            fill_count++;
            grp_ids[slot] = it.point_id;
            grp_sx[slot] = '0;
            grp_sy[slot] = '0;
            grp_sz[slot] = '0;
            grp_cnt[slot] = '0;
          end
          if (grp_cnt[slot] == CountMax) begin
            pending_results.push_back(make_result(StSat, it.point_id, grp_cnt[slot], 1'b1));
          end else begin
            grp_sx[slot] += 48'(it.x_coord);
            grp_sy[slot] += 48'(it.y_coord);
            grp_sz[slot] += 48'(it.z_coord);
            grp_cnt[slot]++;
            pending_results.push_back(make_result(StAdded, it.point_id, grp_cnt[slot],
                                                  1'b1));
          end
        end
      end
      OpDump: begin
        if (fill_count == 0) begin
          pending_results.push_back(make_result(StDumpNone, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < int'(fill_count); i++) begin
            r = make_result(StDumpEnt, grp_ids[i], grp_cnt[i], i == int'(fill_count) - 1);
            r.mean_x = group_mean(grp_sx[i], grp_cnt[i]);
            r.mean_y = group_mean(grp_sy[i], grp_cnt[i]);
            r.mean_z = group_mean(grp_sz[i], grp_cnt[i]);
            pending_results.push_back(r);
          end
        end
      end
      OpClear: begin
        fill_count = 0;
        pending_results.push_back(make_result(StCleared, '0, '0, 1'b1));
      end
      default: ;  // The spare op code is dropped without a result.
    endcase
  endtask

  // Presents one item and holds it until the block takes it; the prediction
  // is made at the accepting edge, so results can never overtake it. Valid
  // stays up until the next item or an idle cycle replaces it.
  task automatic send_item(input in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_table(it);
    items_sent++;
  endtask

  function automatic in_item_t add_item(logic [31:0] gid, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.op = OpAdd;
    it.point_id = gid;
    it.x_coord = x;
    it.y_coord = y;
    it.z_coord = z;
    return it;
  endfunction

  function automatic in_item_t ctl_item(logic [1:0] op);
    in_item_t it;
    it = '0;
    it.op = op;
    it.point_id = $urandom();
    return it;
  endfunction

  // Coordinates are moderate half the time, otherwise an extreme or a full-range value.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
    endcase
  endfunction

  // Directed rows. A typed result is checked here as well as against the
  // predictor; rows with has_exp clear rely on the predictor alone.
  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp_res;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic build_directed();
    stim_row_t row;
    row.has_exp = 1'b1;
    row.item = ctl_item(OpDump);
    row.exp_res = make_result(StDumpNone, '0, '0, 1'b1);
    directed.push_back(row);
    row.item = add_item(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    row.exp_res = make_result(StAdded, 32'hffff_ffff, 16'd1, 1'b1);
    directed.push_back(row);
    row.item = add_item(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    row.exp_res = make_result(StAdded, 32'h0, 16'd1, 1'b1);
    directed.push_back(row);
    row.has_exp = 1'b0;
    row.item = add_item(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    directed.push_back(row);
    row.item = add_item(32'h0, 32'hffff_fffd, 32'h3, 32'h5555_aaaa);
    directed.push_back(row);
    row.item = ctl_item(2'd3);
    directed.push_back(row);
    row.item = ctl_item(OpDump);
    directed.push_back(row);
    // Fill every slot, then one more new ID is refused as table full.
    for (int i = 2; i < int'(Slots); i++) begin
      row.item = add_item(32'h1000 + i, 32'(i), -32'(i), 32'(i * 7));
      directed.push_back(row);
    end
    row.has_exp = 1'b1;
    row.item = add_item(32'hdead_beef, 32'h1, 32'h1, 32'h1);
    row.exp_res = make_result(StFull, 32'hdead_beef, '0, 1'b1);
    directed.push_back(row);
    row.has_exp = 1'b0;
    row.item = ctl_item(OpDump);
    directed.push_back(row);
    row.has_exp = 1'b1;
    row.item = ctl_item(OpClear);
    row.exp_res = make_result(StCleared, '0, '0, 1'b1);
    directed.push_back(row);
  endtask

  // Checks each result taken from the block against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // A long receiver hold-off while the sender keeps offering items.
  initial begin
    recv_hold = 1'b0;
    wait (items_sent >= 60);
    @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // Random traffic: adds, half over a small pool of IDs so that groups grow and
  // half with random IDs so that the table fills, plus occasional dumps, clears and spare ops.
  task automatic random_phase(input int unsigned n);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        send_item(add_item($urandom_range(1, 0) ? 32'($urandom_range(19, 0)) : $urandom(),
                           rand_coord(), rand_coord(), rand_coord()));
      end else if (pick < 91) begin
        send_item(ctl_item(OpDump));
      end else if (pick < 97) begin
        send_item(ctl_item(OpClear));
      end else begin
        send_item(ctl_item(2'd3));
      end
    end
  endtask

  initial begin
    stim_row_t row;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    idle_cycles = 0;
    fill_count = 0;
    stim_done = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 69;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    foreach (directed[i]) begin
      row = directed[i];
      if (row.has_exp && pending_results.size() == 0) begin
        send_item(row.item);
        if (pending_results.size() != 1 || pending_results[0] !== row.exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: predictor disagrees", i);
        end
      end else begin
        send_item(row.item);
      end
      wait (pending_results.size() == 0);
    end

    send_idle_pct = 31;
    recv_idle_pct = 69;
    random_phase(62);
    send_idle_pct = 69;
    recv_idle_pct = 31;
    random_phase(62);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(62);
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d items and %0d results: adds, a full table,",
             items_sent, results_seen);
    $display("dumps of empty and full tables, clears and the spare op, under stalls.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
